@@ rtl/integer_to_ascii_radix_formatter_core_assert.svh @@
// Assertion macros for the integer to ASCII radix formatter.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define IARF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define IARF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/iarf_pkg.sv @@
// Shared types, constants and functions of the integer to ASCII radix formatter.
// No dependencies.
package iarf_pkg;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned NUM_DEC   = 20;
  localparam int unsigned NUM_HEX   = 16;
  localparam int unsigned DIG_W     = NUM_DEC * 4;

  localparam logic [1:0] MODE_DEC32 = 2'd0;
  localparam logic [1:0] MODE_HEX32 = 2'd1;
  localparam logic [1:0] MODE_DEC64 = 2'd2;
  localparam logic [1:0] MODE_HEX64 = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic [63:0] mag;
    logic        is_hex;
    logic        wide;
    logic        minus;
  } cmd_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_e;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_A + {4'd0, d - 4'd10};
    end
    return r;
  endfunction

endpackage

@@ rtl/iarf_fifo.sv @@
// Small first-in first-out queue of words with full and empty flags.
// No dependencies.
module iarf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/iarf_front.sv @@
// Front end: accepts words, derives magnitude, radix and sign, and queues commands.
// Depends on iarf_pkg and iarf_fifo.
module iarf_front #(
  parameter int unsigned CMD_DEPTH = iarf_pkg::CMD_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [63:0]     value_i,
  input  logic [1:0]      mode_i,
  output logic            full_o,
  input  logic            cmd_pop_i,
  output iarf_pkg::cmd_t  cmd_o,
  output logic            cmd_empty_o
);

  iarf_pkg::cmd_t cmd_in;
  logic [31:0]    lo;

  assign lo = value_i[31:0];

  always_comb begin
    cmd_in = '0;
    case (mode_i)
      iarf_pkg::MODE_DEC32: begin
        cmd_in.minus = lo[31];
        cmd_in.mag   = {32'd0, lo[31] ? (32'd0 - lo) : lo};
      end
      iarf_pkg::MODE_HEX32: begin
        cmd_in.is_hex = 1'b1;
        cmd_in.mag    = {32'd0, lo};
      end
      iarf_pkg::MODE_DEC64: begin
        cmd_in.wide = 1'b1;
        cmd_in.mag  = value_i;
      end
      default: begin
        cmd_in.is_hex = 1'b1;
        cmd_in.wide   = 1'b1;
        cmd_in.mag    = value_i;
      end
    endcase
  end

  iarf_fifo #(
    .WIDTH ($bits(iarf_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

@@ rtl/iarf_back.sv @@
// Back end: bit-serial binary to BCD conversion for decimal words, leading zero skip and character emission.
// Depends on iarf_pkg.
module iarf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iarf_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           out_push_o,
  output iarf_pkg::out_t out_o,
  input  logic           out_full_i
);

  localparam int unsigned DW = iarf_pkg::DIG_W;

  iarf_pkg::state_e state_q, state_d;
  logic [DW-1:0] dig_q, dig_d, dig_adj;
  logic [63:0]   bin_q, bin_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [6:0]    bits_q, bits_d;
  logic          minus_q, minus_d;
  logic [3:0]    top;

  assign top = dig_q[DW-1 -: 4];

  always_comb begin
    for (int i = 0; i < iarf_pkg::NUM_DEC; i++) begin
      dig_adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3
                                                      : dig_q[i*4 +: 4];
    end
  end

  always_comb begin
    state_d    = state_q;
    dig_d      = dig_q;
    bin_d      = bin_q;
    cnt_d      = cnt_q;
    bits_d     = bits_q;
    minus_d    = minus_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_o      = '0;
    case (state_q)
      iarf_pkg::S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          minus_d   = cmd_i.minus;
          if (cmd_i.is_hex) begin
            if (cmd_i.wide) begin
              dig_d = {cmd_i.mag, {(DW - 64){1'b0}}};
              cnt_d = 5'(iarf_pkg::NUM_HEX);
            end else begin
              dig_d = {cmd_i.mag[31:0], {(DW - 32){1'b0}}};
              cnt_d = 5'(iarf_pkg::NUM_HEX / 2);
            end
            state_d = iarf_pkg::S_SKIP;
          end else begin
            dig_d   = '0;
            bin_d   = cmd_i.wide ? cmd_i.mag : {cmd_i.mag[31:0], 32'd0};
            bits_d  = cmd_i.wide ? 7'd64 : 7'd32;
            state_d = iarf_pkg::S_CONV;
          end
        end
      end
      iarf_pkg::S_CONV: begin
        dig_d  = {dig_adj[DW-2:0], bin_q[63]};
        bin_d  = {bin_q[62:0], 1'b0};
        bits_d = bits_q - 7'd1;
        if (bits_q == 7'd1) begin
          cnt_d   = 5'(iarf_pkg::NUM_DEC);
          state_d = iarf_pkg::S_SKIP;
        end
      end
      iarf_pkg::S_SKIP: begin
        if (top == 4'd0 && cnt_q != 5'd1) begin
          dig_d = {dig_q[DW-5:0], 4'd0};
          cnt_d = cnt_q - 5'd1;
        end else begin
          state_d = minus_q ? iarf_pkg::S_SIGN : iarf_pkg::S_EMIT;
        end
      end
      iarf_pkg::S_SIGN: begin
        out_o.character = iarf_pkg::CH_MINUS;
        out_o.last      = 1'b0;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = iarf_pkg::S_EMIT;
        end
      end
      iarf_pkg::S_EMIT: begin
        out_o.character = iarf_pkg::glyph(top);
        out_o.last      = (cnt_q == 5'd1);
        if (!out_full_i) begin
          out_push_o = 1'b1;
          dig_d      = {dig_q[DW-5:0], 4'd0};
          cnt_d      = cnt_q - 5'd1;
          if (cnt_q == 5'd1) begin
            state_d = iarf_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = iarf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iarf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    bin_q   <= bin_d;
    cnt_q   <= cnt_d;
    bits_q  <= bits_d;
    minus_q <= minus_d;
  end

endmodule

@@ rtl/integer_to_ascii_radix_formatter_core.sv @@
// Integer to ASCII radix formatter, top level: front end, back end and result queue.
// The back end takes one word at a time: it accepts a command while idle, converts decimal
// words bit by bit to BCD, skips leading zeros, emits a minus sign for a negative 32-bit
// decimal word and then the digits; emission stalls while the result queue is full.
// Reset is asynchronous, active low, and empties both queues and idles the converter.
module integer_to_ascii_radix_formatter_core #(
  parameter int unsigned CMD_DEPTH = iarf_pkg::CMD_DEPTH,
  parameter int unsigned OUT_DEPTH = iarf_pkg::OUT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] value_i,
  input  logic [1:0]  mode_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  character_o,
  output logic        last_o
);

  iarf_pkg::cmd_t cmd;
  logic           cmd_empty, cmd_pop;
  iarf_pkg::out_t res_in, res_out;
  logic           res_push, res_full;

  iarf_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .value_i     (value_i),
    .mode_i      (mode_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  iarf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_push_o  (res_push),
    .out_o       (res_in),
    .out_full_i  (res_full)
  );

  iarf_fifo #(
    .WIDTH ($bits(iarf_pkg::out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign character_o = res_out.character;
  assign last_o      = res_out.last;

endmodule

@@ rtl/iarf_checker.sv @@
// Port-level checks on the result side of the integer to ASCII radix formatter.
// Depends on iarf_pkg and integer_to_ascii_radix_formatter_core_assert.svh.
`include "integer_to_ascii_radix_formatter_core_assert.svh"

module iarf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] character_o,
  input logic       last_o
);

  logic waiting;
  logic is_glyph;
  logic is_minus;

  assign waiting  = !empty && !pop;
  assign is_glyph = character_o inside {[iarf_pkg::CH_ZERO:iarf_pkg::CH_NINE],
                                        [iarf_pkg::CH_A:iarf_pkg::CH_F],
                                        iarf_pkg::CH_MINUS};
  assign is_minus = !empty && (character_o == iarf_pkg::CH_MINUS);

  `IARF_ASSERT(a_hold, waiting |=> (!empty && $stable({character_o, last_o})), "word changed")
  `IARF_ASSERT(a_glyph, !empty |-> is_glyph, "character outside the digit set")
  `IARF_ASSERT(a_sign_not_last, is_minus |-> !last_o, "minus sign marked last")
  `IARF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> empty, "result queue not empty after reset")

endmodule

bind integer_to_ascii_radix_formatter_core iarf_checker u_iarf_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for integer_to_ascii_radix_formatter_core: table, then random words.
// Expected characters: table text, else a local SystemVerilog formatter; depends on iarf_pkg.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  mode;
    string       text;
  } text_row_t;

  localparam int NUM_ROWS = 24;
  localparam int NUM_RANDOM = 256;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] value_i = '0;
  logic [1:0]  mode_i = iarf_pkg::MODE_DEC32;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  character_o;
  logic        last_o;

  iarf_pkg::out_t expected_chars [$];
  int             failures = 0;
  logic           steady = 1'b0;
  text_row_t      number_table [NUM_ROWS];

  integer_to_ascii_radix_formatter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .mode_i     (mode_i),
    .empty      (empty),
    .pop        (pop),
    .character_o(character_o),
    .last_o     (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("integer_to_ascii_radix_formatter_core regression: fail");
    $finish;
  end

  function automatic void format_number(input logic [63:0] value, input logic [1:0] mode);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [31:0] low_neg;
    logic        minus;
    logic [3:0]  d;
    logic [7:0]  digits [$];
    minus = 1'b0;
    radix = 64'd10;
    low_neg = ~value[31:0] + 32'd1;
    case (mode)
      iarf_pkg::MODE_DEC32: begin
        minus = value[31];
        mag = minus ? {32'd0, low_neg} : {32'd0, value[31:0]};
      end
      iarf_pkg::MODE_HEX32: begin
        mag = {32'd0, value[31:0]};
        radix = 64'd16;
      end
      iarf_pkg::MODE_DEC64: begin
        mag = value;
      end
      default: begin
        mag = value;
        radix = 64'd16;
      end
    endcase
    do begin
      d = 4'(mag % radix);
      digits.push_front(d < 4'd10 ? iarf_pkg::CH_ZERO + 8'(d)
                                  : iarf_pkg::CH_A + 8'(d - 4'd10));
      mag = mag / radix;
    end while (mag != 64'd0);
    if (minus) begin
      expected_chars.push_back('{character: iarf_pkg::CH_MINUS, last: 1'b0});
    end
    foreach (digits[i]) begin
      expected_chars.push_back('{character: digits[i], last: i == digits.size() - 1});
    end
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          k;
    v = {$urandom(), $urandom()};
    case ($urandom_range(5))
      0: ;
      1: v = 64'($urandom_range(99));
      2: begin
        k = $urandom_range(19);
        v = 64'd1;
        repeat (k) v = v * 64'd10;
        v = v - 64'($urandom_range(1));
      end
      3: begin
        k = $urandom_range(15);
        v = (64'd1 << (4 * k)) - 64'($urandom_range(1));
      end
      4: v = {v[63:32], 32'd0 - 32'($urandom_range(1000))};
      default: v = v >> $urandom_range(63);
    endcase
    return v;
  endfunction

  task automatic send_word(input logic [63:0] value, input logic [1:0] mode,
                           input string text);
    while (!steady && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    value_i <= value;
    mode_i <= mode;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    if (text.len() == 0) begin
      format_number(value, mode);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        expected_chars.push_back('{character: text[i], last: i == text.len() - 1});
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: character %h last %b", character_o, last_o);
        failures++;
      end else begin
        if (character_o !== expected_chars[0].character) begin
          $error("character: expected %h, got %h", expected_chars[0].character, character_o);
          failures++;
        end
        if (last_o !== expected_chars[0].last) begin
          $error("last: expected %b, got %b", expected_chars[0].last, last_o);
          failures++;
        end
        void'(expected_chars.pop_front());
      end
    end
    pop <= rst_ni && (steady || $urandom_range(99) >= 12);
  end

  initial begin
    number_table = '{
      '{64'd0,                    iarf_pkg::MODE_DEC32, "0"},
      '{64'd0,                    iarf_pkg::MODE_HEX32, "0"},
      '{64'd0,                    iarf_pkg::MODE_DEC64, "0"},
      '{64'd0,                    iarf_pkg::MODE_HEX64, "0"},
      '{64'h0000_0000_7FFF_FFFF,  iarf_pkg::MODE_DEC32, "2147483647"},
      '{64'h0000_0000_8000_0000,  iarf_pkg::MODE_DEC32, "-2147483648"},
      '{64'h0000_0000_FFFF_FFFF,  iarf_pkg::MODE_DEC32, "-1"},
      '{64'h0000_0000_FFFF_FFF6,  iarf_pkg::MODE_DEC32, "-10"},
      '{64'hFFFF_FFFF_0000_0000,  iarf_pkg::MODE_DEC32, "0"},
      '{64'hDEAD_BEEF_0000_0001,  iarf_pkg::MODE_DEC32, "1"},
      '{64'h0000_0000_1234_5678,  iarf_pkg::MODE_DEC32, ""},
      '{64'h0000_0000_FFFF_FFFF,  iarf_pkg::MODE_HEX32, "FFFFFFFF"},
      '{64'h0000_0000_8000_0000,  iarf_pkg::MODE_HEX32, "80000000"},
      '{64'hFFFF_FFFF_0000_0000,  iarf_pkg::MODE_HEX32, "0"},
      '{64'h0123_4567_89AB_CDEF,  iarf_pkg::MODE_HEX32, "89ABCDEF"},
      '{64'hFFFF_FFFF_FFFF_FFFF,  iarf_pkg::MODE_DEC64, "18446744073709551615"},
      '{64'd10000000000000000000, iarf_pkg::MODE_DEC64, ""},
      '{64'd9,                    iarf_pkg::MODE_DEC64, "9"},
      '{64'd10,                   iarf_pkg::MODE_DEC64, "10"},
      '{64'h5555_AAAA_0F0F_F0F0,  iarf_pkg::MODE_DEC64, ""},
      '{64'hFFFF_FFFF_FFFF_FFFF,  iarf_pkg::MODE_HEX64, "FFFFFFFFFFFFFFFF"},
      '{64'h0123_4567_89AB_CDEF,  iarf_pkg::MODE_HEX64, "123456789ABCDEF"},
      '{64'h0000_0000_0000_000A,  iarf_pkg::MODE_HEX64, "A"},
      '{64'h8000_0000_0000_0000,  iarf_pkg::MODE_HEX64, "8000000000000000"}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (number_table[i]) begin
      send_word(number_table[i].value, number_table[i].mode, number_table[i].text);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady <= n >= 100 && n < 160;
      send_word(random_value(), 2'($urandom_range(3)), "");
    end
    push <= 1'b0;
    steady <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (failures == 0) begin
      $display("integer_to_ascii_radix_formatter_core regression: pass");
    end else begin
      $display("integer_to_ascii_radix_formatter_core regression: fail");
    end
    $finish;
  end

endmodule
